### design/cau_pkg.sv
`default_nettype none
package cau_pkg;

   // Operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Quotient bits kept by the divider; larger quotients saturate anyway
   localparam int QBITS = 17;
   localparam int DBITS = 32;
   localparam int RBITS = DBITS + QBITS;

   typedef struct packed {
      logic [1:0]          mode;
      logic signed [15:0]  a_re;
      logic signed [15:0]  a_im;
      logic signed [15:0]  b_re;
      logic signed [15:0]  b_im;
   } cau_req_type;

   typedef struct packed {
      logic signed [15:0]  res_re;
      logic signed [15:0]  res_im;
      logic                overflow;
      logic                div_by_zero;
   } cau_rsp_type;

   // One item inside the divider stages
   typedef struct packed {
      logic [1:0]          mode;
      logic signed [33:0]  dir_re;
      logic signed [33:0]  dir_im;
      logic                neg_re;
      logic                neg_im;
      logic                big_re;
      logic                big_im;
      logic                dz;
      logic [RBITS-1:0]    rem_re;
      logic [RBITS-1:0]    rem_im;
      logic [QBITS-1:0]    q_re;
      logic [QBITS-1:0]    q_im;
      logic [DBITS-1:0]    den;
   } cau_div_type;

   typedef struct packed {
      logic signed [15:0]  val;
      logic                ovf;
   } cau_sat_type;

   function automatic cau_sat_type cau_sat(input logic signed [33:0] v);
      cau_sat_type r;
      if (v > 34'sd32767) begin
         r.val = 16'sh7fff;
         r.ovf = 1'b1;
      end else if (v < -34'sd32768) begin
         r.val = 16'sh8000;
         r.ovf = 1'b1;
      end else begin
         r.val = v[15:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/complex_arithmetic_unit.sv
`default_nettype none
// Channel   Ports                                Payload
// request   req_valid, req_ready, req_data       mode, a_re, a_im, b_re, b_im
// response  rsp_valid, rsp_ready, rsp_data       res_re, res_im, overflow, div_by_zero
//
// One item per cycle unless a stall on rsp_ready holds the pipeline. Registers:
// a product stage, a sum stage, a range check and 17 restoring-divide stages
// (one quotient bit each), then the output register. All modes share the path.
// Reset clears the valid bits only. A stall on rsp_ready freezes the whole
// pipeline, so req_ready follows rsp_ready while the output register is full.
module complex_arithmetic_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  cau_pkg::cau_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output cau_pkg::cau_rsp_type rsp_data
);
   import cau_pkg::*;

   logic adv;

   // Stage 1: products and add/subtract
   logic               v1_ff;
   logic [1:0]         mode1_ff;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [31:0]        p_bb_re_ff, p_bb_im_ff;
   logic signed [16:0] as_re_ff, as_im_ff;
   logic signed [31:0] p_bb_re_in, p_bb_im_in;

   // Stage 2: sums, magnitudes, denominator
   logic               v2_ff;
   cau_div_type        s2_ff, s2_in;

   // Divider stages
   logic               vd_ff [0:QBITS];
   cau_div_type        pd_ff [0:QBITS];
   cau_div_type        pd_in [0:QBITS];

   cau_rsp_type        rsp_ff, rsp_in;
   logic               rsp_v_ff;

   assign adv       = ~rsp_v_ff | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   assign p_bb_re_in = req_data.b_re * req_data.b_re;
   assign p_bb_im_in = req_data.b_im * req_data.b_im;

   always_ff @(posedge clock) begin
      if (adv) begin
         mode1_ff   <= req_data.mode;
         p_rr_ff    <= req_data.a_re * req_data.b_re;
         p_ii_ff    <= req_data.a_im * req_data.b_im;
         p_ri_ff    <= req_data.a_re * req_data.b_im;
         p_ir_ff    <= req_data.a_im * req_data.b_re;
         p_bb_re_ff <= p_bb_re_in;
         p_bb_im_ff <= p_bb_im_in;
         if (req_data.mode == OP_SUB) begin
            as_re_ff <= 17'(req_data.a_re) - 17'(req_data.b_re);
            as_im_ff <= 17'(req_data.a_im) - 17'(req_data.b_im);
         end else begin
            as_re_ff <= 17'(req_data.a_re) + 17'(req_data.b_re);
            as_im_ff <= 17'(req_data.a_im) + 17'(req_data.b_im);
         end
      end
   end

   // Stage 2 logic
   always_comb begin
      logic signed [32:0] m_re, m_im, n_re, n_im;
      logic [32:0]        mag_re, mag_im;
      m_re = 33'(p_rr_ff) - 33'(p_ii_ff);
      m_im = 33'(p_ri_ff) + 33'(p_ir_ff);
      n_re = 33'(p_rr_ff) + 33'(p_ii_ff);
      n_im = 33'(p_ir_ff) - 33'(p_ri_ff);
      mag_re = n_re[32] ? 33'(-n_re) : 33'(n_re);
      mag_im = n_im[32] ? 33'(-n_im) : 33'(n_im);
      s2_in        = '0;
      s2_in.mode   = mode1_ff;
      s2_in.neg_re = n_re[32];
      s2_in.neg_im = n_im[32];
      s2_in.den    = p_bb_re_ff + p_bb_im_ff;
      s2_in.rem_re = RBITS'({mag_re, 8'd0});
      s2_in.rem_im = RBITS'({mag_im, 8'd0});
      if (mode1_ff == OP_MUL) begin
         s2_in.dir_re = 34'(m_re >>> 8);
         s2_in.dir_im = 34'(m_im >>> 8);
      end else begin
         s2_in.dir_re = 34'(as_re_ff);
         s2_in.dir_im = 34'(as_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
      end
   end

   // Range check: quotient would need more than QBITS bits
   always_comb begin
      logic [RBITS-1:0] lim;
      lim          = {s2_ff.den, QBITS'(0)};
      pd_in[0]        = s2_ff;
      pd_in[0].dz     = (s2_ff.den == '0);
      pd_in[0].big_re = (s2_ff.rem_re >= lim);
      pd_in[0].big_im = (s2_ff.rem_im >= lim);
   end

   // Restoring divide, one quotient bit per stage, MSB first
   for (genvar k = 0; k < QBITS; k++) begin : g_div
      always_comb begin
         logic [RBITS-1:0] trial;
         trial = RBITS'(pd_ff[k].den) << (QBITS - 1 - k);
         pd_in[k+1] = pd_ff[k];
         if (pd_ff[k].rem_re >= trial) begin
            pd_in[k+1].rem_re               = pd_ff[k].rem_re - trial;
            pd_in[k+1].q_re[QBITS - 1 - k]  = 1'b1;
         end
         if (pd_ff[k].rem_im >= trial) begin
            pd_in[k+1].rem_im               = pd_ff[k].rem_im - trial;
            pd_in[k+1].q_im[QBITS - 1 - k]  = 1'b1;
         end
      end
   end

   for (genvar k = 0; k <= QBITS; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (adv) begin
            pd_ff[k] <= pd_in[k];
         end
      end
   end

   // Final scaling, sign and saturation
   always_comb begin
      cau_div_type        f;
      cau_sat_type        sr, si;
      logic signed [33:0] vr, vi;
      f  = pd_ff[QBITS];
      vr = f.dir_re;
      vi = f.dir_im;
      if (f.mode == OP_DIV) begin
         if (f.big_re) begin
            vr = f.neg_re ? -34'sd65536 : 34'sd65536;
         end else begin
            vr = f.neg_re ? -34'({1'b0, f.q_re}) : 34'({1'b0, f.q_re});
         end
         if (f.big_im) begin
            vi = f.neg_im ? -34'sd65536 : 34'sd65536;
         end else begin
            vi = f.neg_im ? -34'({1'b0, f.q_im}) : 34'({1'b0, f.q_im});
         end
         if (f.dz) begin
            vr = '0;
            vi = '0;
         end
      end
      sr = cau_sat(vr);
      si = cau_sat(vi);
      rsp_in.res_re      = sr.val;
      rsp_in.res_im      = si.val;
      rsp_in.overflow    = sr.ovf | si.ovf;
      rsp_in.div_by_zero = (f.mode == OP_DIV) && f.dz;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         rsp_v_ff <= 1'b0;
         for (int i = 0; i <= QBITS; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int i = 1; i <= QBITS; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         rsp_v_ff <= vd_ff[QBITS];
      end
   end

endmodule
`default_nettype wire
